// ===== rtl/oaht_pkg.sv =====
`default_nettype none
package oaht_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_DUP      = 3'd3;
	localparam logic [2:0] ST_REBUILT  = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	localparam logic [1:0] LAST_STEP = 2'd3;
	localparam logic [5:0] CAP_STEPS [4] = '{6'd11, 6'd19, 6'd29, 6'd37};

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_RS_WAIT, S_MOD, S_PINIT, S_PRD, S_PCHK,
		S_GRD, S_GWR, S_GROW, S_RCHK, S_RRD, S_RLD, S_FIN
	} state_t;

	typedef enum logic [2:0] {
		R_KEEP, R_MISS, R_HIT, R_INS, R_FULL, R_REBUILT, R_READ
	} res_t;

	typedef struct packed {
		logic load_in;
		logic mod_start;
		logic load_buf;
		logic mod_step;
		logic probe_init;
		logic st_rd;
		logic probe_adv;
		logic st_wr;
		logic rd_idx;
		logic g_init0;
		logic g_init_nest;
		logic g_rd;
		logic g_wr;
		logic grow;
		logic ri_next;
		logic buf_rd;
		res_t res;
		logic hit_dup;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       rebuild;
		logic       mod_last;
		logic       p_stop;
		logic       p_hit;
		logic       p_place;
		logic       last_step;
		logic       g_last;
		logic       ri_more;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/oaht_ram.sv =====
`default_nettype none
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/oaht_ctrl.sv =====
`default_nettype none
module oaht_ctrl import oaht_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (sts.op == OP_INSERT || sts.op == OP_FIND) state_d = S_MOD;
				else if (sts.op == OP_READ) state_d = S_RS_WAIT;
				else state_d = S_FIN;
			end
			S_RS_WAIT: state_d = S_FIN;
			S_MOD:     if (sts.mod_last) state_d = S_PINIT;
			S_PINIT:   state_d = S_PRD;
			S_PRD:     state_d = S_PCHK;
			S_PCHK: begin
				if (!sts.p_stop) begin
					state_d = S_PRD;
				end else if (sts.rebuild) begin
					if (!sts.p_hit && !sts.p_place && !sts.last_step) state_d = S_GRD;
					else state_d = S_RCHK;
				end else if (sts.op == OP_INSERT && !sts.p_hit && !sts.p_place
						&& !sts.last_step) begin
					state_d = S_GRD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_GRD:     state_d = S_GWR;
			S_GWR:     state_d = sts.g_last ? S_GROW : S_GRD;
			S_GROW:    state_d = S_RCHK;
			S_RCHK:    state_d = sts.ri_more ? S_RRD : S_FIN;
			S_RRD:     state_d = S_RLD;
			S_RLD:     state_d = S_MOD;
			S_FIN:     if (sts.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res = R_KEEP;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			S_DECODE: begin
				if (sts.op == OP_INSERT || sts.op == OP_FIND) cmd.mod_start = 1'b1;
				else if (sts.op == OP_READ) cmd.rd_idx = 1'b1;
				else cmd.res = R_MISS;
			end
			S_RS_WAIT: cmd.res = R_READ;
			S_MOD:     cmd.mod_step = 1'b1;
			S_PINIT:   cmd.probe_init = 1'b1;
			S_PRD:     cmd.st_rd = 1'b1;
			S_PCHK: begin
				if (!sts.p_stop) begin
					cmd.probe_adv = 1'b1;
				end else if (sts.rebuild) begin
					if (sts.p_hit) begin
						cmd.ri_next = 1'b1;
					end else if (sts.p_place) begin
						cmd.st_wr = 1'b1;
						cmd.ri_next = 1'b1;
					end else if (!sts.last_step) begin
						cmd.g_init_nest = 1'b1;
					end else begin
						cmd.ri_next = 1'b1;
					end
				end else if (sts.op == OP_FIND) begin
					cmd.res = sts.p_hit ? R_HIT : R_MISS;
				end else if (sts.p_hit) begin
					cmd.res = R_HIT;
					cmd.hit_dup = 1'b1;
				end else if (sts.p_place) begin
					cmd.st_wr = 1'b1;
					cmd.res = R_INS;
				end else if (sts.last_step) begin
					cmd.res = R_FULL;
				end else begin
					cmd.g_init0 = 1'b1;
				end
			end
			S_GRD:  cmd.g_rd = 1'b1;
			S_GWR:  cmd.g_wr = 1'b1;
			S_GROW: cmd.grow = 1'b1;
			S_RCHK: if (!sts.ri_more) cmd.res = R_REBUILT;
			S_RRD:  cmd.buf_rd = 1'b1;
			S_RLD:  cmd.load_buf = 1'b1;
			S_FIN:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/oaht_dp.sv =====
`default_nettype none
module oaht_dp import oaht_pkg::*; #(
	parameter int MAX_SLOTS = 37,
	parameter int KEY_BITS  = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmd_t                       cmd,
	output sts_t                            sts,
	input  wire logic [1:0]                 op,
	input  wire logic [KEY_BITS-1:0]        key,
	input  wire logic [31:0]                value,
	input  wire logic [5:0]                 slot_index,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [2:0]                      status,
	output logic [5:0]                      slot,
	output logic [KEY_BITS-1:0]             slot_key,
	output logic [31:0]                     slot_value,
	output logic [5:0]                      capacity,
	output logic [5:0]                      entry_count
);
	localparam int AW   = $clog2(MAX_SLOTS);
	localparam int RW   = AW + 1;
	localparam int CNTW = $clog2(MAX_SLOTS + 1);
	localparam int BW   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int DW   = KEY_BITS + 32;

	logic [1:0]          op_q;
	logic [5:0]          idx_q;
	logic [KEY_BITS-1:0] wkey_q, mkey_q;
	logic [31:0]         wval_q;
	logic [RW-1:0]       rem_q;
	logic [BW-1:0]       bit_q;
	logic [AW-1:0]       p_q, gi_q;
	logic [CNTW-1:0]     c_q, w_q, ri_q, n_q, count_q;
	logic [1:0]          step_q;
	logic                rebuild_q, nested_q;
	logic [MAX_SLOTS-1:0] valid_q;
	logic [2:0]          res_status_q;
	logic [5:0]          res_slot_q;
	logic [KEY_BITS-1:0] res_key_q;
	logic [31:0]         res_val_q;

	logic [6:0]          cap7;
	logic [RW-1:0]       m;
	logic [RW:0]         rem_t, sum;
	logic [CNTW-1:0]     c_next, start;
	logic                in_range;
	logic [AW-1:0]       ia, st_addr;
	logic [DW-1:0]       st_rdata, buf_rdata;
	logic [KEY_BITS-1:0] cur_key;
	logic [31:0]         cur_val;
	logic                st_we, st_re, buf_we;

	assign cap7 = ({1'b0, CAP_STEPS[step_q]} > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS)
			: {1'b0, CAP_STEPS[step_q]};
	assign m = RW'(cap7);
	assign rem_t = {rem_q, mkey_q[KEY_BITS-1]};
	assign c_next = c_q + 1'b1;
	assign sum = (RW+1)'(p_q) + (RW+1)'(c_next);
	assign start = (count_q <= ri_q) ? ri_q + 1'b1 - count_q : CNTW'(1);
	assign in_range = 7'(idx_q) < cap7;
	assign ia = in_range ? idx_q[AW-1:0] : '0;

	assign cur_key = valid_q[p_q] ? st_rdata[DW-1:32] : '0;
	assign cur_val = valid_q[p_q] ? st_rdata[31:0] : '0;

	assign st_addr = cmd.rd_idx ? ia : (cmd.g_rd ? gi_q : p_q);
	assign st_we = cmd.st_wr;
	assign st_re = cmd.rd_idx | cmd.g_rd | cmd.st_rd;
	assign buf_we = cmd.g_wr && valid_q[gi_q] && (w_q < CNTW'(MAX_SLOTS));

	oaht_ram #(.WIDTH(DW), .DEPTH(MAX_SLOTS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.re    (st_re),
		.addr  (st_addr),
		.wdata ({wkey_q, wval_q}),
		.rdata (st_rdata)
	);

	oaht_ram #(.WIDTH(DW), .DEPTH(MAX_SLOTS)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.re    (cmd.buf_rd),
		.addr  (buf_we ? w_q[AW-1:0] : ri_q[AW-1:0]),
		.wdata (st_rdata),
		.rdata (buf_rdata)
	);

	always_comb begin
		sts.op        = op_q;
		sts.rebuild   = rebuild_q;
		sts.mod_last  = bit_q == BW'(KEY_BITS - 1);
		sts.p_hit     = cur_key == wkey_q;
		sts.p_stop    = sts.p_hit || (cur_key == '0) || !(RW'(c_next) < m);
		sts.p_place   = (cur_key == '0) && (RW'(c_q) < (m >> 1));
		sts.last_step = step_q == LAST_STEP;
		sts.g_last    = RW'(gi_q) + 1'b1 == m;
		sts.ri_more   = ri_q < n_q;
		sts.out_free  = !out_valid || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= op;
			idx_q  <= slot_index;
			wkey_q <= key;
			wval_q <= value;
		end
		if (cmd.load_buf) begin
			wkey_q <= buf_rdata[DW-1:32];
			wval_q <= buf_rdata[31:0];
		end
		if (cmd.mod_start || cmd.load_buf) begin
			mkey_q <= cmd.load_buf ? buf_rdata[DW-1:32] : wkey_q;
			rem_q  <= '0;
			bit_q  <= '0;
		end else if (cmd.mod_step) begin
			mkey_q <= mkey_q << 1;
			rem_q  <= (rem_t >= (RW+1)'(m)) ? RW'(rem_t - (RW+1)'(m)) : RW'(rem_t);
			bit_q  <= bit_q + 1'b1;
		end
		if (cmd.probe_init) begin
			p_q <= AW'(rem_q);
			c_q <= '0;
		end else if (cmd.probe_adv) begin
			c_q <= c_next;
			p_q <= (sum >= (RW+1)'(m)) ? AW'(sum - (RW+1)'(m)) : AW'(sum);
		end
		if (cmd.g_init0 || cmd.g_init_nest) begin
			gi_q     <= '0;
			w_q      <= cmd.g_init0 ? '0 : start;
			ri_q     <= cmd.g_init0 ? '0 : start;
			nested_q <= cmd.g_init_nest;
		end else begin
			if (cmd.g_wr) gi_q <= gi_q + 1'b1;
			if (buf_we) w_q <= w_q + 1'b1;
			if (cmd.ri_next) ri_q <= ri_q + 1'b1;
		end
		if (cmd.grow && !nested_q) n_q <= w_q;
		case (cmd.res)
			R_MISS, R_FULL, R_REBUILT: begin
				res_status_q <= (cmd.res == R_MISS) ? ST_MISS
						: ((cmd.res == R_FULL) ? ST_FULL : ST_REBUILT);
				res_slot_q   <= '0;
				res_key_q    <= '0;
				res_val_q    <= '0;
			end
			R_HIT: begin
				res_status_q <= cmd.hit_dup ? ST_DUP : ST_FOUND;
				res_slot_q   <= 6'(p_q);
				res_key_q    <= cur_key;
				res_val_q    <= cur_val;
			end
			R_INS: begin
				res_status_q <= ST_INSERTED;
				res_slot_q   <= 6'(p_q);
				res_key_q    <= wkey_q;
				res_val_q    <= wval_q;
			end
			R_READ: begin
				res_status_q <= (in_range && valid_q[ia]) ? ST_FOUND : ST_MISS;
				res_slot_q   <= idx_q;
				res_key_q    <= (in_range && valid_q[ia]) ? st_rdata[DW-1:32] : '0;
				res_val_q    <= (in_range && valid_q[ia]) ? st_rdata[31:0] : '0;
			end
			default: res_status_q <= res_status_q;
		endcase
		if (cmd.out_load) begin
			status      <= res_status_q;
			slot        <= res_slot_q;
			slot_key    <= res_key_q;
			slot_value  <= res_val_q;
			capacity    <= 6'(cap7);
			entry_count <= 6'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			step_q    <= '0;
			rebuild_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.grow) begin
				valid_q <= '0;
				count_q <= '0;
				step_q  <= step_q + 1'b1;
			end else if (cmd.st_wr) begin
				valid_q[p_q] <= 1'b1;
				count_q      <= count_q + 1'b1;
			end
			if (cmd.load_in) rebuild_q <= 1'b0;
			else if (cmd.g_init0) rebuild_q <= 1'b1;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/open_address_hash_table_top.sv =====
// Channel   Valid / ready          Payload
// input     in_valid / in_ready    op, key, value, slot_index
// output    out_valid / out_ready  status, slot, slot_key, slot_value, capacity, entry_count
// One item is worked on at a time; the next is taken once the result has moved to the
// output register. The home slot of a find or insert is found by a bit-serial remainder unit,
// and each probed slot is read and then checked. A rebuild adds a gather sweep over the old
// slots into a buffer and a full probe per reinserted entry. A slot read goes straight to the
// addressed slot. Reset clears the slot valid bits at once, so no clearing pass is needed.
// A stalled output holds the block in its final state until the transfer completes.
`default_nettype none
module open_address_hash_table_top import oaht_pkg::*; #(
	parameter int MAX_SLOTS = 37,
	parameter int KEY_BITS  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          op,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic signed [31:0]  value,
	input  wire logic [5:0]          slot_index,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               status,
	output logic [5:0]               slot,
	output logic [KEY_BITS-1:0]      slot_key,
	output logic signed [31:0]       slot_value,
	output logic [5:0]               capacity,
	output logic [5:0]               entry_count
);
	cmd_t cmd;
	sts_t sts;

	oaht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	oaht_dp #(.MAX_SLOTS(MAX_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.key         (key),
		.value       (value),
		.slot_index  (slot_index),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.slot        (slot),
		.slot_key    (slot_key),
		.slot_value  (slot_value),
		.capacity    (capacity),
		.entry_count (entry_count)
	);
endmodule
`default_nettype wire

// ===== rtl/oaht_chk.sv =====
`default_nettype none
module oaht_chk import oaht_pkg::*; #(
	parameter int KEY_BITS = 16
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [2:0]          status,
	input wire logic [5:0]          slot,
	input wire logic [KEY_BITS-1:0] slot_key,
	input wire logic [5:0]          capacity,
	input wire logic [5:0]          entry_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output dropped before its transfer.");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(slot))
		else $error("Output payload changed while stalled.");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= capacity)
		else $error("More entries than slots.");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FULL)
		else $error("Undefined status code.");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_INSERTED |-> slot < capacity && slot_key != '0)
		else $error("Insert reported outside the table.");
endmodule

bind open_address_hash_table_top oaht_chk #(.KEY_BITS(KEY_BITS)) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.slot        (slot),
	.slot_key    (slot_key),
	.capacity    (capacity),
	.entry_count (entry_count)
);
`default_nettype wire
